// ===== design/dal_pkg.sv =====
package dal_pkg;

  // Fixed field widths of the ports
  localparam int unsigned OP_W   = 2;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned HELD_W = 4;

  // Defaults for the top-level parameters
  localparam int unsigned DEFAULT_LIST_DEPTH = 8;
  localparam int unsigned DEFAULT_ADDR_BYTES = 6;

  // Operation codes; the unused code falls to a default arm
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic match;    // register the per-entry compare vector
    logic apply;    // update the list and the result registers
  } ctrl_cmd_t;

endpackage

// ===== design/dal_ctrl.sv =====
module dal_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dal_pkg::ctrl_cmd_t  cmd_o
);

  dal_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dal_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dal_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dal_pkg::ST_MATCH;
      end
      dal_pkg::ST_MATCH:  state_d = dal_pkg::ST_APPLY;
      dal_pkg::ST_APPLY:  state_d = dal_pkg::ST_RESULT;
      dal_pkg::ST_RESULT: begin
        if (out_ready_i) state_d = dal_pkg::ST_IDLE;
      end
      default: state_d = dal_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.match   = 1'b0;
    cmd_o.apply   = 1'b0;
    unique case (state_q)
      dal_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dal_pkg::ST_MATCH:  cmd_o.match = 1'b1;
      dal_pkg::ST_APPLY:  cmd_o.apply = 1'b1;
      dal_pkg::ST_RESULT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/dal_datapath.sv =====
module dal_datapath #(
  parameter int unsigned LIST_DEPTH = dal_pkg::DEFAULT_LIST_DEPTH,
  parameter int unsigned ADDR_BYTES = dal_pkg::DEFAULT_ADDR_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dal_pkg::ctrl_cmd_t          cmd_i,
  input  logic [dal_pkg::OP_W-1:0]    operation_i,
  input  logic [dal_pkg::TYPE_W-1:0]  dev_type_i,
  input  logic [dal_pkg::ADDR_W-1:0]  address_i,
  output logic                        hit_o,
  output logic [dal_pkg::HELD_W-1:0]  entries_held_o,
  output logic                        evicted_oldest_o
);

  // Stored address bits: the low ADDR_BYTES bytes, capped at the port width
  localparam int unsigned STORE_W = (ADDR_BYTES * 8 < dal_pkg::ADDR_W) ?
                                    ADDR_BYTES * 8 : dal_pkg::ADDR_W;
  localparam int unsigned CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  dal_pkg::op_e              op_q;
  logic [dal_pkg::TYPE_W-1:0] type_q;
  logic [STORE_W-1:0]        addr_q;

  logic [dal_pkg::TYPE_W-1:0] type_store_q [LIST_DEPTH];
  logic [STORE_W-1:0]        addr_store_q [LIST_DEPTH];

  logic [CNT_W-1:0]          count_q, count_d;
  logic [LIST_DEPTH-1:0]     match_q, match_d;
  logic                      res_hit_q, res_hit_d;
  logic                      res_evict_q, res_evict_d;

  logic                      hit;
  logic                      full;
  logic                      shift_en;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= dal_pkg::op_e'(operation_i);
      type_q <= dev_type_i;
      addr_q <= address_i[STORE_W-1:0];
    end
  end

  // Per-entry compare, only positions below the count take part
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match_d[i] = (CNT_W'(i) < count_q) && (type_store_q[i] == type_q) &&
                   (addr_store_q[i] == addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) match_q <= match_d;
  end

  // List update decision
  always_comb begin
    hit         = |match_q;
    full        = (count_q == CNT_W'(LIST_DEPTH));
    shift_en    = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = count_q[IDX_W-1:0];
    count_d     = count_q;
    res_hit_d   = 1'b0;
    res_evict_d = 1'b0;
    case (op_q)
      dal_pkg::OP_LOOKUP: res_hit_d = hit;
      dal_pkg::OP_ADD: begin
        res_hit_d = hit;
        if (!hit) begin
          if (full) begin
            shift_en    = cmd_i.apply;
            res_evict_d = 1'b1;
          end else begin
            wr_en   = cmd_i.apply;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      dal_pkg::OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  // Count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_hit_q   <= 1'b0;
      res_evict_q <= 1'b0;
    end else if (cmd_i.apply) begin
      count_q     <= count_d;
      res_hit_q   <= res_hit_d;
      res_evict_q <= res_evict_d;
    end
  end

  // Entry storage: shift down on eviction with the new entry at the top, else write the next free position
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_entry
    logic [dal_pkg::TYPE_W-1:0] shift_type;
    logic [STORE_W-1:0]        shift_addr;

    if (g == LIST_DEPTH - 1) begin : g_top
      assign shift_type = type_q;
      assign shift_addr = addr_q;
    end else begin : g_mid
      assign shift_type = type_store_q[g+1];
      assign shift_addr = addr_store_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (shift_en) begin
        type_store_q[g] <= shift_type;
        addr_store_q[g] <= shift_addr;
      end else if (wr_en && (wr_idx == IDX_W'(g))) begin
        type_store_q[g] <= type_q;
        addr_store_q[g] <= addr_q;
      end
    end
  end

  assign hit_o            = res_hit_q;
  assign evicted_oldest_o = res_evict_q;
  assign entries_held_o   = dal_pkg::HELD_W'(count_q);

endmodule

// ===== design/device_address_allowlist.sv =====
// Device address allowlist: an ordered list of up to LIST_DEPTH approved
// devices, each an address type byte plus the low ADDR_BYTES bytes of a
// 48-bit address, oldest first.
// Request channel (in_valid_i/in_ready_o): operation_i selects lookup, add
// or clear; code 3 leaves the list unchanged. Result channel
// (out_valid_o/out_ready_i): hit_o, entries_held_o (count after the
// operation) and evicted_oldest_o, one result per request.
// Sequence: a request transfer is followed by a compare state and an
// update state, after which the result is valid in the result state.
// One request is in flight at a time, so a new request is taken in the
// cycle after the result transfer. The compare of all entries in
// parallel and the registered update of the shift list set this
// sequence.
// Receiver stall: the result holds in its output registers and no new
// request is taken until it transfers.
// Reset: the list is empty and both channels are idle; stored entries are
// never read above the count, so they need no clearing.
module device_address_allowlist #(
  parameter int unsigned LIST_DEPTH = dal_pkg::DEFAULT_LIST_DEPTH,
  parameter int unsigned ADDR_BYTES = dal_pkg::DEFAULT_ADDR_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dal_pkg::OP_W-1:0]    operation_i,
  input  logic [dal_pkg::TYPE_W-1:0]  dev_type_i,
  input  logic [dal_pkg::ADDR_W-1:0]  address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [dal_pkg::HELD_W-1:0]  entries_held_o,
  output logic                        evicted_oldest_o
);

  dal_pkg::ctrl_cmd_t cmd;

  // Sequencer
  dal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // List storage, compare and result registers
  dal_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .ADDR_BYTES (ADDR_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .dev_type_i       (dev_type_i),
    .address_i        (address_i),
    .hit_o            (hit_o),
    .entries_held_o   (entries_held_o),
    .evicted_oldest_o (evicted_oldest_o)
  );

endmodule
